// File: sv/lowest_free_id_allocator_unit_macros.svh
// assertion macros for the lowest free id allocator
`ifndef LOWEST_FREE_ID_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LFIA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfia check failed");

// next-cycle implication
`define LFIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfia check failed");

`endif

// File: sv/lfia_pkg.sv
`default_nettype none
package lfia_pkg;

   localparam int MAX_IDS   = 256;
   localparam int ID_W      = (MAX_IDS > 2) ? $clog2(MAX_IDS) : 1;
   localparam int COUNT_W   = $clog2(MAX_IDS + 1);
   localparam int REQ_ID_W  = 8;
   localparam int HANDLE_W  = 32;
   localparam int IDX_W     = (ID_W > REQ_ID_W) ? ID_W : REQ_ID_W;
   localparam int WORD_W    = 16;
   localparam int WBIT_W    = $clog2(WORD_W);
   localparam int NUM_WORDS = (MAX_IDS + WORD_W - 1) / WORD_W;
   localparam int WPTR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int POS_W     = WPTR_W + WBIT_W;

   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic       load;
      logic       scan_next;
      logic       set_used;
      logic       clr_used;
      logic       rd_en;
      logic       rsp_fire;
      logic [1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       full;
      logic       empty;
      logic       hit;
      logic       word_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: sv/lowest_free_id_allocator_unit.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------
// request   | start high, busy low      | req_action, req_id, req_new_handle
// response  | rsp_strobe, one cycle     | rsp_status, rsp_got_id, rsp_got_handle
//
// free, lookup and unknown actions, and an allocate to a full map, answer from S_DECIDE
// other allocates pass S_DECIDE, then stay in S_SCAN until the 16-bit word of the used
// map that holds the lowest free id is found; one word is examined per cycle
// reset clears the used map and live count at once, the handle table is not cleared
// a new item is taken in the cycle its predecessor's strobe shows
// the receiver cannot stall: each result is shown once and is gone
`default_nettype none
module lowest_free_id_allocator_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_action,
   input  wire logic [lfia_pkg::REQ_ID_W-1:0]    req_id,
   input  wire logic [lfia_pkg::HANDLE_W-1:0]    req_new_handle,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [lfia_pkg::REQ_ID_W-1:0]         rsp_got_id,
   output logic [lfia_pkg::HANDLE_W-1:0]         rsp_got_handle
);

   lfia_pkg::dp_cmd_type    cmd;
   lfia_pkg::dp_status_type stat;

   lfia_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   lfia_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_id         (req_id),
      .req_new_handle (req_new_handle),
      .rsp_status     (rsp_status),
      .rsp_got_id     (rsp_got_id),
      .rsp_got_handle (rsp_got_handle)
   );

endmodule
`default_nettype wire

// File: sv/lfia_datapath.sv
`default_nettype none
module lfia_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lfia_pkg::dp_cmd_type                cmd,
   output lfia_pkg::dp_status_type                  stat,
   input  wire logic [1:0]                          req_action,
   input  wire logic [lfia_pkg::REQ_ID_W-1:0]       req_id,
   input  wire logic [lfia_pkg::HANDLE_W-1:0]       req_new_handle,
   output logic [1:0]                               rsp_status,
   output logic [lfia_pkg::REQ_ID_W-1:0]            rsp_got_id,
   output logic [lfia_pkg::HANDLE_W-1:0]            rsp_got_handle
);

   logic [1:0]                      req_action_ff;
   logic [lfia_pkg::ID_W-1:0]       req_idx_ff;
   logic                            req_in_range_ff;
   logic [lfia_pkg::HANDLE_W-1:0]   req_handle_ff;
   logic [lfia_pkg::MAX_IDS-1:0]    used_ff;
   logic [lfia_pkg::COUNT_W-1:0]    count_ff;
   logic [lfia_pkg::WPTR_W-1:0]     ptr_ff;
   logic [1:0]                      rsp_status_ff;
   logic [lfia_pkg::REQ_ID_W-1:0]   rsp_got_id_ff;
   logic [lfia_pkg::HANDLE_W-1:0]   rsp_got_handle_ff;

   logic [lfia_pkg::HANDLE_W-1:0]   handle_mem [lfia_pkg::MAX_IDS];

   logic [lfia_pkg::IDX_W-1:0]      req_id_wide;
   logic [lfia_pkg::WORD_W-1:0]     scan_word;
   logic [lfia_pkg::WBIT_W-1:0]     first_free;
   logic [lfia_pkg::POS_W-1:0]      pos;
   logic [lfia_pkg::POS_W-1:0]      found_pos;
   logic [lfia_pkg::ID_W-1:0]       found_id;
   logic [lfia_pkg::IDX_W-1:0]      found_id_wide;

   assign req_id_wide = lfia_pkg::IDX_W'(req_id);

   // current scan word, bits past the last id read as taken
   always_comb begin
      scan_word = '0;
      pos       = '0;
      for (int b = 0; b < lfia_pkg::WORD_W; b++) begin
         pos = {ptr_ff, lfia_pkg::WBIT_W'(b)};
         if (int'(pos) < lfia_pkg::MAX_IDS) begin
            scan_word[b] = used_ff[pos[lfia_pkg::ID_W-1:0]];
         end else begin
            scan_word[b] = 1'b1;
         end
      end
   end

   // lowest zero bit of the word
   always_comb begin
      first_free = '0;
      for (int b = lfia_pkg::WORD_W - 1; b >= 0; b--) begin
         if (!scan_word[b]) begin
            first_free = lfia_pkg::WBIT_W'(b);
         end
      end
   end

   assign found_pos     = {ptr_ff, first_free};
   assign found_id      = found_pos[lfia_pkg::ID_W-1:0];
   assign found_id_wide = lfia_pkg::IDX_W'(found_id);

   assign stat.action    = req_action_ff;
   assign stat.full      = (count_ff == lfia_pkg::COUNT_W'(lfia_pkg::MAX_IDS));
   assign stat.empty     = (count_ff == '0);
   assign stat.hit       = req_in_range_ff && used_ff[req_idx_ff];
   assign stat.word_free = !(&scan_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.set_used) begin
            used_ff[found_id] <= 1'b1;
            count_ff          <= count_ff + lfia_pkg::COUNT_W'(1);
         end else if (cmd.clr_used) begin
            used_ff[req_idx_ff] <= 1'b0;
            count_ff            <= count_ff - lfia_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_action_ff   <= req_action;
         req_idx_ff      <= req_id_wide[lfia_pkg::ID_W-1:0];
         req_in_range_ff <= (int'(req_id_wide) < lfia_pkg::MAX_IDS);
         req_handle_ff   <= req_new_handle;
         ptr_ff          <= '0;
      end else if (cmd.scan_next) begin
         ptr_ff <= ptr_ff + lfia_pkg::WPTR_W'(1);
      end
      if (cmd.rsp_fire) begin
         rsp_status_ff <= cmd.status;
         rsp_got_id_ff <= cmd.set_used ? found_id_wide[lfia_pkg::REQ_ID_W-1:0] : '0;
      end
   end

   // handle table, read port doubles as the result handle register
   always_ff @(posedge clock) begin
      if (cmd.set_used) begin
         handle_mem[found_id] <= req_handle_ff;
      end
      if (cmd.rd_en) begin
         rsp_got_handle_ff <= handle_mem[req_idx_ff];
      end else if (cmd.rsp_fire) begin
         rsp_got_handle_ff <= '0;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_got_id     = rsp_got_id_ff;
   assign rsp_got_handle = rsp_got_handle_ff;

endmodule
`default_nettype wire

// File: sv/lfia_controller.sv
`default_nettype none
module lfia_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_strobe,
   output lfia_pkg::dp_cmd_type         cmd,
   input  wire lfia_pkg::dp_status_type stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_strobe_ff;
   logic      rsp_strobe_in;

   always_comb begin
      cmd           = '0;
      cmd.status    = lfia_pkg::ST_OK;
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            case (stat.action)
               lfia_pkg::ACT_ALLOC: begin
                  if (stat.full) begin
                     cmd.rsp_fire  = 1'b1;
                     cmd.status    = lfia_pkg::ST_FULL;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               lfia_pkg::ACT_FREE: begin
                  cmd.rsp_fire  = 1'b1;
                  rsp_strobe_in = 1'b1;
                  if (stat.empty) begin
                     cmd.status = lfia_pkg::ST_EMPTY;
                  end else if (!stat.hit) begin
                     cmd.status = lfia_pkg::ST_NOT_FOUND;
                  end else begin
                     cmd.clr_used = 1'b1;
                  end
               end
               lfia_pkg::ACT_LOOKUP: begin
                  cmd.rsp_fire  = 1'b1;
                  rsp_strobe_in = 1'b1;
                  if (stat.hit) begin
                     cmd.rd_en = 1'b1;
                  end else begin
                     cmd.status = lfia_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  cmd.rsp_fire  = 1'b1;
                  cmd.status    = lfia_pkg::ST_NOT_FOUND;
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            // a free bit exists since the count is below capacity
            if (stat.word_free) begin
               cmd.set_used  = 1'b1;
               cmd.rsp_fire  = 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule
`default_nettype wire

// File: sv/lfia_checker.sv
`default_nettype none
`include "lowest_free_id_allocator_unit_macros.svh"
module lfia_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic [1:0]                       rsp_status,
   input wire logic [lfia_pkg::REQ_ID_W-1:0]    rsp_got_id,
   input wire logic [lfia_pkg::HANDLE_W-1:0]    rsp_got_handle
);

   // result appears only once the unit is idle again
   `LFIA_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // an accepted item makes the unit busy, with no strobe, in the following cycle
   `LFIA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)

   // failed requests carry no id or handle
   `LFIA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_strobe && rsp_status != lfia_pkg::ST_OK, rsp_got_id == '0 && rsp_got_handle == '0)

   // one item gives exactly one strobe
   `LFIA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind lowest_free_id_allocator_unit lfia_checker u_lfia_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_got_id     (rsp_got_id),
   .rsp_got_handle (rsp_got_handle)
);
`default_nettype wire
